### hw/rtl/bdt_pkg.sv
// Package for the box density threshold block: sizes, register indexes,
// operation codes and output constants. No dependencies.
package bdt_pkg;
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxRadius = 15;

  localparam int CfgWidth  = 9;
  localparam int CfgIdxW   = 2;
  localparam int SumW      = 18;
  localparam int PixW      = 8;

  localparam logic [CfgIdxW-1:0] RegFrameWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindowRadius = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [PixW-1:0] MaskOn  = 8'hff;
  localparam logic [PixW-1:0] MaskOff = 8'h00;
  localparam logic [SumW-1:0] SumLimit = 18'h3ffff;
endpackage

### hw/rtl/bdt_in_if.sv
// Request channel interfaces (input and output) with valid/ready handshake.
// Depends on bdt_pkg.
interface bdt_in_if;
  import bdt_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [PixW-1:0] pixel;
  modport source (output valid, output operation, output pixel, input ready);
  modport sink (input valid, input operation, input pixel, output ready);
endinterface

interface bdt_out_if;
  import bdt_pkg::*;
  logic valid;
  logic ready;
  logic [PixW-1:0] mask_value;
  logic [SumW-1:0] window_sum;
  logic last_pixel;
  modport source (output valid, output mask_value, output window_sum, output last_pixel,
                  input ready);
  modport sink (input valid, input mask_value, input window_sum, input last_pixel,
                output ready);
endinterface

### hw/rtl/bdt_cut_div.sv
// Threshold divide by ten: reciprocal multiply of a registered numerator, result registered.
// Depends on bdt_pkg.
module bdt_cut_div
  import bdt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SumW-1:0] peak,
  output logic            busy,
  output logic [SumW-1:0] cut
);
  localparam int NumW  = SumW + 4;
  localparam int Shift = 25;
  // ceil(2^25 / 10); exact floor(n/10) for every n below 2^22
  localparam logic [NumW-1:0] Recip = NumW'(3355444);

  logic [NumW-1:0]   num;
  logic [2*NumW-1:0] prod;

  assign prod = num * Recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      num  <= '0;
      cut  <= '0;
    end else if (start) begin
      // 9*peak + 5
      num  <= ({4'd0, peak} << 3) + {4'd0, peak} + NumW'(5);
      busy <= 1'b1;
    end else if (busy) begin
      cut  <= prod[Shift +: SumW];
      busy <= 1'b0;
    end
  end
endmodule

### hw/rtl/box_density_threshold.sv
// Box density threshold: load a frame, window-sum every pixel, threshold at 0.9*max.
// Loads are taken while idle. After the last load the frame pass runs rows then columns
// in sub-phased window steps, then the threshold divide; requests stall meanwhile. A
// read goes through the store read register, then the output register, held while an
// earlier result still waits. Synchronous active-high reset; stores are not cleared.
// Depends on bdt_pkg, the interfaces and bdt_cut_div.
module box_density_threshold
  import bdt_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight,
  parameter int MAX_RADIUS = DefMaxRadius
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  bdt_in_if.sink              in_ch,
  bdt_out_if.source           out_ch
);
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PosW  = $clog2(Depth + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int AccW  = SumW + 2;

  // configuration
  logic [CfgWidth-1:0] frame_width, frame_height;
  logic [3:0] window_radius;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [PosW-1:0] size;

  always_comb begin
    if (frame_width == '0) w_eff = XW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(frame_width);
    if (frame_height == '0) h_eff = YW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(frame_height);
    if (32'(window_radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(window_radius);
  end

  // frame size; recomputed from registers, a single multiply
  assign size = PosW'(w_eff * h_eff);

  // memories
  logic [PixW-1:0] pixel_mem [Depth];
  logic [SumW-1:0] row_mem   [Depth];
  logic [SumW-1:0] sum_mem   [Depth];

  typedef enum logic [2:0] {
    S_IDLE, S_RPASS, S_CPASS, S_DIV, S_RD
  } state_t;
  state_t state;

  logic [PosW-1:0] load_position, read_position;
  logic [SumW-1:0] peak_sum, cut_level;

  // sequencer for a sliding pass. A line has n elements; step j runs over
  // j = 0 .. n+r-1. For each output x = j - r (if >=0) the accumulator holds
  // the sum of elements x-r..x+r. Each step: add element j (if < n), write
  // the output, then subtract element j-2r (if >= 0). Two store reads a step
  // are done one after the other by phase.
  logic [XW+RW:0] j;          // step within line
  logic [XW-1:0]  line;       // row index (row pass) or column (col pass)
  logic           phase;      // 0: read add element, 1: read sub element
  logic [AccW-1:0] acc;
  logic [SumW-1:0] rdat;

  logic [XW+RW:0] nlen;       // elements in current line
  logic [XW+RW:0] r2;
  assign nlen = (state == S_RPASS) ? (XW+RW+1)'(w_eff) : (XW+RW+1)'(h_eff);
  assign r2   = (XW+RW+1)'({r_eff, 1'b0});

  // element address of position p along current line
  function automatic logic [AddrW-1:0] elem_addr(input logic rowp, input logic [XW+RW:0] p,
      input logic [XW-1:0] ln, input logic [XW-1:0] w);
    logic [AddrW+XW:0] a;
    if (rowp) a = (AddrW+XW+1)'(ln) * (AddrW+XW+1)'(w) + (AddrW+XW+1)'(p);
    else a = (AddrW+XW+1)'(p) * (AddrW+XW+1)'(w) + (AddrW+XW+1)'(ln);
    return a[AddrW-1:0];
  endfunction

  logic [XW+RW:0] sub_pos, out_pos;
  logic add_ok, sub_ok, out_ok;
  logic [XW+RW:0] jm;
  logic [XW+RW:0] last_j;     // final step of a line
  assign jm      = j - r2;
  assign sub_pos = jm;
  assign sub_ok  = (j >= r2);
  assign add_ok  = (j < nlen);
  assign out_pos = j - (XW+RW+1)'(r_eff);
  assign out_ok  = (j >= (XW+RW+1)'(r_eff));
  assign last_j  = nlen + (XW+RW+1)'(r_eff) - 1'b1;

  logic [XW-1:0] nlines;
  assign nlines = (state == S_RPASS) ? XW'(h_eff) : XW'(w_eff);

  // store read data register (shared unit input)
  logic [AddrW-1:0] raddr;
  always_comb begin
    raddr = elem_addr(state == S_RPASS, phase ? sub_pos : j, line, XW'(w_eff));
    if (state == S_RD || state == S_IDLE) raddr = AddrW'(read_position);
  end

  always_ff @(posedge clk) begin
    if (state == S_RPASS) rdat <= SumW'(pixel_mem[raddr]);
    else rdat <= row_mem[raddr];
  end
  logic [SumW-1:0] sum_rd;
  always_ff @(posedge clk) sum_rd <= sum_mem[raddr];

  // pass sequencing: sub-phase A issue add read (phase0), B issue sub read
  // (phase1) and consume add data, C consume sub data and write output.
  // Implemented via the sub-phase counter sp.
  logic [1:0] sp;
  logic [AccW-1:0] acc_add;
  logic [SumW-1:0] sat;
  logic [SumW-1:0] peak_in;
  assign acc_add = acc + AccW'(rdat);
  assign sat = (acc > AccW'(SumLimit)) ? SumLimit : acc[SumW-1:0];
  // peak including the output written on the final step
  assign peak_in = (out_ok && sat > peak_sum) ? sat : peak_sum;

  logic div_start, div_busy;
  logic [SumW-1:0] div_cut;
  bdt_cut_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .peak(peak_in),
    .busy(div_busy), .cut(div_cut)
  );
  assign div_start = (state == S_CPASS) && (sp == 2'd2) && (j == last_j)
                     && (line == nlines - 1'b1);

  logic take_in, take_out, out_valid;
  logic [PixW-1:0] mask_r;
  logic [SumW-1:0] sum_r;
  logic last_r;
  logic complete;
  assign complete = (load_position == size);
  // a waiting result does not hold off requests; a read waits in S_RD instead
  assign in_ch.ready = (state == S_IDLE);
  assign take_in  = in_ch.valid && in_ch.ready;
  assign take_out = out_valid && out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.mask_value = mask_r;
  assign out_ch.window_sum = sum_r;
  assign out_ch.last_pixel = last_r;

  logic [PosW-1:0] lp_base;
  assign lp_base = (load_position >= size) ? '0 : load_position;

  always_ff @(posedge clk) begin
    if (take_in && in_ch.operation == OpLoad) pixel_mem[AddrW'(lp_base)] <= in_ch.pixel;
    if (state == S_RPASS && sp == 2'd2 && out_ok)
      row_mem[elem_addr(1'b1, out_pos, line, XW'(w_eff))] <= sat;
    if (state == S_CPASS && sp == 2'd2 && out_ok)
      sum_mem[elem_addr(1'b0, out_pos, line, XW'(w_eff))] <= sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= CfgWidth'(256); frame_height <= CfgWidth'(256);
      window_radius <= 4'd2;
      state <= S_IDLE; load_position <= '0; read_position <= '0;
      peak_sum <= '0; cut_level <= '0; out_valid <= 1'b0;
      j <= '0; line <= '0; sp <= '0; acc <= '0; phase <= 1'b0;
    end else begin
      if (take_out && state != S_RD) out_valid <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          RegFrameWidth:   frame_width <= cfg_data;
          RegFrameHeight:  frame_height <= cfg_data;
          RegWindowRadius: window_radius <= cfg_data[3:0];
          default: ;
        endcase
        if (cfg_index == RegFrameWidth || cfg_index == RegFrameHeight ||
            cfg_index == RegWindowRadius) begin
          load_position <= '0; read_position <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (take_in) begin
            if (in_ch.operation == OpLoad) begin
              load_position <= lp_base + 1'b1;
              if (lp_base + 1'b1 == size) begin
                state <= S_RPASS; j <= '0; line <= '0; sp <= '0;
                acc <= '0; phase <= 1'b0; read_position <= '0;
              end else if (load_position >= size) read_position <= '0;
            end else if (complete) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          // sum_rd now valid for read_position; wait for a free output register
          if (!out_valid || take_out) begin
            mask_r <= (sum_rd > cut_level) ? MaskOn : MaskOff;
            sum_r <= sum_rd;
            last_r <= (read_position + 1'b1 == size);
            out_valid <= 1'b1;
            read_position <= (read_position + 1'b1 >= size) ? '0 : read_position + 1'b1;
            state <= S_IDLE;
          end
        end
        S_RPASS, S_CPASS: begin
          case (sp)
            2'd0: begin phase <= 1'b1; sp <= 2'd1; end
            2'd1: begin
              if (add_ok) acc <= acc_add;
              phase <= 1'b0; sp <= 2'd2;
            end
            2'd2: begin
              logic [AccW-1:0] a2;
              a2 = acc;
              if (sub_ok) a2 = acc - AccW'(rdat);
              // output uses acc before subtraction (sum of x-r..x+r)
              if (state == S_CPASS && out_ok && sat > peak_sum) peak_sum <= sat;
              sp <= 2'd0;
              if (j == last_j) begin
                j <= '0; acc <= '0;
                if (line == nlines - 1'b1) begin
                  line <= '0;
                  if (state == S_RPASS) begin
                    state <= S_CPASS; peak_sum <= '0;
                  end else state <= S_DIV;
                end else line <= line + 1'b1;
              end else begin
                j <= j + 1'b1;
                acc <= a2;
              end
            end
            default: sp <= 2'd0;
          endcase
        end
        S_DIV: begin
          if (!div_busy && !div_start) begin
            cut_level <= div_cut; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("request taken while busy");
  a_rd_gives_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> out_valid) else $error("read lost");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (load_position <= size || $past(cfg_write)))
    else $error("load position past frame");
`endif
endmodule

### tb/sv/tb_top.sv
// Self-checking bench for box_density_threshold: loads small frames, reads the
// window sums and masks back, and checks them against a local frame predictor.
// Depends on bdt_pkg, bdt_in_if, bdt_out_if and the box_density_threshold RTL.
module tb_top;
  import bdt_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] mask;
    logic [SumW-1:0] sum;
    logic            last;
  } px_result_t;

  // Frame predictor plus queue of expected read results
  class frame_scoreboard;
    int unsigned     reg_w = 256, reg_h = 256, reg_r = 2;
    logic [PixW-1:0] pixels[DefMaxWidth*DefMaxHeight];
    logic [SumW-1:0] sums[DefMaxWidth*DefMaxHeight];
    logic [SumW-1:0] cut;
    int unsigned     load_pos, read_pos;
    px_result_t      awaited[$];
    int              errors;

    function int unsigned eff_w();
      return reg_w == 0 ? 1 : (reg_w > DefMaxWidth ? DefMaxWidth : reg_w);
    endfunction
    function int unsigned eff_h();
      return reg_h == 0 ? 1 : (reg_h > DefMaxHeight ? DefMaxHeight : reg_h);
    endfunction
    function int unsigned eff_r();
      return reg_r > DefMaxRadius ? DefMaxRadius : reg_r;
    endfunction
    function int unsigned frame_size();
      return eff_w() * eff_h();
    endfunction
    function bit frame_ready();
      return load_pos == frame_size();
    endfunction
    // cycles the frame pass may still need after the last load
    function int unsigned pass_cycles();
      return 3 * (2 * frame_size() + eff_r() * (eff_w() + eff_h())) + 64;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
      case (idx)
        RegFrameWidth:   reg_w = val & 'h1ff;
        RegFrameHeight:  reg_h = val & 'h1ff;
        RegWindowRadius: reg_r = val & 'hf;
        default: return;
      endcase
      load_pos = 0;
      read_pos = 0;
    endfunction

    // brute-force centred, zero-padded window sums and the cut level
    function void sum_frame();
      int w, h, r, s, peak;
      w = eff_w(); h = eff_h(); r = eff_r(); peak = 0;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          s = 0;
          for (int yy = y - r; yy <= y + r; yy++)
            for (int xx = x - r; xx <= x + r; xx++)
              if (yy >= 0 && yy < h && xx >= 0 && xx < w) s += pixels[yy*w + xx];
          if (s > SumLimit) s = SumLimit;
          sums[y*w + x] = SumW'(s);
          if (s > peak) peak = s;
        end
      cut = SumW'((9 * peak + 5) / 10);
    endfunction

    function void note_request(logic op, logic [PixW-1:0] pix);
      int unsigned size;
      px_result_t  e;
      size = frame_size();
      if (op == OpLoad) begin
        if (load_pos >= size) begin
          load_pos = 0;
          read_pos = 0;
        end
        pixels[load_pos] = pix;
        load_pos++;
        if (load_pos == size) begin
          sum_frame();
          read_pos = 0;
        end
      end else if (load_pos == size) begin
        e.sum  = sums[read_pos];
        e.mask = (sums[read_pos] > cut) ? MaskOn : MaskOff;
        e.last = (read_pos + 1 == size);
        awaited.push_back(e);
        read_pos = (read_pos + 1 >= size) ? 0 : read_pos + 1;
      end
    endfunction

    function void check_result(px_result_t got);
      px_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = awaited.pop_front();
      if (got.mask !== e.mask || got.sum !== e.sum || got.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected mask %0d sum %0d last %0d, got mask %0d sum %0d last %0d",
                   e.mask, e.sum, e.last, got.mask, got.sum, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgWidth-1:0] cfg_data;

  bdt_in_if  in_ch();
  bdt_out_if out_ch();

  box_density_threshold dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  frame_scoreboard sb = new();
  bit calm;            // no idling on either side while set
  int pushed;          // requests accepted so far
  int unsigned stall;  // receiver stall cycles left

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every accepted result, then maybe stall at random unless calm
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.mask_value, out_ch.window_sum, out_ch.last_pixel});
      n = calm ? 0 : $urandom_range(0, 3);
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        stall <= n - 1;
      end
    end else if (!out_ch.ready) begin
      if (stall == 0) out_ch.ready <= 1'b1;
      else stall <= stall - 1;
    end
  end

  // Send one request after a random gap; returns at the accepting edge
  task automatic push(logic op, logic [PixW-1:0] pix);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pixel <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, pix);
    pushed++;
  endtask

  // Quiet the sender and let all results drain, then let any frame pass finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (sb.pass_cycles()) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= RegFrameWidth;   cfg_data <= CfgWidth'(w);
    @(posedge clk); sb.write_reg(RegFrameWidth, w);
    cfg_index <= RegFrameHeight;  cfg_data <= CfgWidth'(h);
    @(posedge clk); sb.write_reg(RegFrameHeight, h);
    cfg_index <= RegWindowRadius; cfg_data <= CfgWidth'(r);
    @(posedge clk); sb.write_reg(RegWindowRadius, r);
    cfg_write <= 1'b0;
  endtask

  // Pixel styles: uniform, sparse spikes (so the mask varies), extremes only
  function automatic logic [PixW-1:0] draw_pixel(int style);
    case (style)
      0: return PixW'($urandom_range(0, 255));
      1: return ($urandom_range(0, 9) == 0) ? PixW'($urandom_range(128, 255)) : 8'd0;
      default: return $urandom_range(0, 1) ? 8'hff : 8'h00;
    endcase
  endfunction

  // Load a frame with stray reads mixed in (ignored while incomplete)
  task automatic load_frame(int style, int unsigned count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) push(OpRead, PixW'($urandom_range(0, 255)));
      push(OpLoad, draw_pixel(style));
    end
  endtask

  task automatic read_back(int unsigned count);
    repeat (count) push(OpRead, PixW'($urandom_range(0, 255)));
  endtask

  initial begin
    int size;
    bit paused;
    rst = 1'b1;
    cfg_write <= 1'b0; cfg_index <= RegFrameWidth; cfg_data <= '0;
    in_ch.valid <= 1'b0; in_ch.operation <= OpLoad; in_ch.pixel <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single pixel, zero width clamped, clamped width/height, big radius
    set_frame(1, 1, 0);
    push(OpRead, 8'h00);                  // read before any frame: ignored
    push(OpLoad, 8'hff);
    read_back(3);                         // wraps, last flag every time
    set_frame(0, 1, 0);
    push(OpLoad, 8'h00);
    read_back(1);
    set_frame(511, 1, 15);                // width clamps to the maximum
    load_frame(0, 256);
    read_back(4);
    set_frame(1, 300, 15);                // height clamps to the maximum
    load_frame(2, 256);
    read_back(3);
    set_frame(4, 3, 15);                  // window covers whole frame
    load_frame(0, 12);
    read_back(12);
    push(OpLoad, 8'h55);                  // new frame after a complete one
    push(OpRead, 8'hff);                  // ignored: frame incomplete again

    // Random phases, mostly small frames so the frame pass stays short
    paused = 0;
    while (pushed < 1750) begin
      int unsigned w, h, r;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
      r = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      calm = ($urandom_range(0, 3) == 0);
      set_frame(w, h, r);
      size = sb.frame_size();
      repeat ($urandom_range(0, 2)) push(OpRead, PixW'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) begin
        load_frame($urandom_range(0, 2), size);
        read_back($urandom_range(1, 2 * size));
        if (!paused) begin
          // sender waits for every outstanding result before going on
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (sb.awaited.size() != 0) @(posedge clk);
          paused = 1;
        end
      end
      // sometimes leave a partial frame for the next register write to discard
      if ($urandom_range(0, 3) == 0) load_frame(0, $urandom_range(0, size - 1));
    end

    in_ch.valid <= 1'b0;
    calm = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
